>>> sv/timed_hold_gesture_recognizer_unit_defines.svh
// Assertion macros shared by the timed hold gesture recognizer RTL.
`ifndef TIMED_HOLD_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH
`define TIMED_HOLD_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion that is not checked while reset is high.
`define THGR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define THGR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define THGR_ASSERT(name, clk, rst, prop, msg)
`define THGR_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> sv/thgr_pkg.sv
// Package with types, codes and reset values for the timed hold gesture recognizer.
package thgr_pkg;

  localparam int TIME_BITS_DEFAULT = 48;
  localparam int WINDOW_W = 20;
  localparam int HOLD_MIN_W = 20;
  localparam int HOLDS_W = 4;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int KIND_W = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [WINDOW_W-1:0] WINDOW_MS_RESET = WINDOW_W'(10000);
  localparam logic [HOLD_MIN_W-1:0] HOLD_MIN_MS_RESET = HOLD_MIN_W'(1000);
  localparam logic [HOLDS_W-1:0] REQUIRED_HOLDS_RESET = HOLDS_W'(3);

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MIN_MS = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRED_HOLDS = CFG_INDEX_W'(2);

  localparam logic [KIND_W-1:0] KIND_PRESS = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_RELEASE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(2);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FAULT    = 2'd2,
    ST_ARMED    = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    armed_flag;
  } thgr_result_t;

endpackage

>>> sv/thgr_step.sv
// Next-state and status logic for one button event of the gesture recognizer.
module thgr_step #(
  parameter int TIME_BITS = thgr_pkg::TIME_BITS_DEFAULT
) (
  input  logic [thgr_pkg::KIND_W-1:0]     kind,
  input  logic [TIME_BITS-1:0]            event_time,
  input  logic [thgr_pkg::WINDOW_W-1:0]   window_ms,
  input  logic [thgr_pkg::HOLD_MIN_W-1:0] hold_min_ms,
  input  logic [thgr_pkg::HOLDS_W-1:0]    required_holds,
  input  logic                            holding,
  input  logic [thgr_pkg::HOLDS_W-1:0]    good_holds,
  input  logic [TIME_BITS-1:0]            window_open_time,
  input  logic [TIME_BITS-1:0]            press_time,
  input  logic                            armed_latch,
  output logic                            holding_next,
  output logic [thgr_pkg::HOLDS_W-1:0]    good_holds_next,
  output logic [TIME_BITS-1:0]            window_open_time_next,
  output logic [TIME_BITS-1:0]            press_time_next,
  output logic                            armed_latch_next,
  output thgr_pkg::thgr_result_t          result
);
  import thgr_pkg::*;

  logic [TIME_BITS-1:0] since_window;
  logic [TIME_BITS-1:0] held_for;
  logic [TIME_BITS-1:0] window_ext;
  logic [TIME_BITS-1:0] hold_min_ext;
  logic                 window_expired;
  logic                 long_enough;
  logic [HOLDS_W-1:0]   holds_inc;
  status_t              status;

  assign since_window = event_time - window_open_time;
  assign held_for = event_time - press_time;
  assign window_ext = {{(TIME_BITS-WINDOW_W){1'b0}}, window_ms};
  assign hold_min_ext = {{(TIME_BITS-HOLD_MIN_W){1'b0}}, hold_min_ms};
  assign window_expired = since_window > window_ext;
  assign long_enough = held_for >= hold_min_ext;
  assign holds_inc = good_holds + HOLDS_W'(1);

  always_comb begin
    holding_next = holding;
    good_holds_next = good_holds;
    window_open_time_next = window_open_time;
    press_time_next = press_time;
    armed_latch_next = armed_latch;
    status = ST_OK;
    case (kind)
      KIND_PRESS: begin
        if (armed_latch) begin
          status = ST_REJECTED;
        end else if (!holding) begin
          if (good_holds != '0 && event_time < window_open_time) begin
            holding_next = 1'b0;
            good_holds_next = '0;
            window_open_time_next = '0;
            press_time_next = '0;
            armed_latch_next = 1'b0;
            status = ST_FAULT;
          end else begin
            if (good_holds == '0) begin
              window_open_time_next = event_time;
            end else if (window_expired) begin
              window_open_time_next = event_time;
              good_holds_next = '0;
            end
            press_time_next = event_time;
            holding_next = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        if (armed_latch) begin
          status = ST_REJECTED;
        end else if (holding) begin
          holding_next = 1'b0;
          if (event_time < press_time || press_time < window_open_time) begin
            good_holds_next = '0;
            window_open_time_next = '0;
            press_time_next = '0;
            armed_latch_next = 1'b0;
            status = ST_FAULT;
          end else if (window_expired) begin
            good_holds_next = '0;
          end else if (long_enough) begin
            good_holds_next = holds_inc;
            if (holds_inc >= required_holds) begin
              armed_latch_next = 1'b1;
              status = ST_ARMED;
            end
          end
        end
      end
      KIND_CLEAR: begin
        holding_next = 1'b0;
        good_holds_next = '0;
        window_open_time_next = '0;
        press_time_next = '0;
        armed_latch_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result.status = status;
  assign result.armed_flag = armed_latch_next;

endmodule

>>> sv/timed_hold_gesture_recognizer_unit.sv
// Top level of the timed hold gesture recognizer with stream ports and configuration.
// Each event transfer on the slave side yields exactly one result transfer on the
// master side, in order. One event is taken every clock cycle unless the master side
// stalls a full output register: the state update and the status for an event are
// settled in the cycle of its transfer and stored with the result in the output
// register, so the next event sees the new state at once. s_tready is high whenever
// the output register is empty or being drained in the same cycle. Configuration
// writes are registered and are meant to happen while no event is in flight.
module timed_hold_gesture_recognizer_unit #(
  parameter int TIME_BITS = thgr_pkg::TIME_BITS_DEFAULT,
  localparam int IN_DATA_W = ((TIME_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Bits from the lowest up: event_time, then zero padding.
  input  logic [IN_DATA_W-1:0]             s_tdata,
  // Bits from the lowest up: kind.
  input  logic [thgr_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Bits from the lowest up: status (2), armed_flag (1), then zero padding.
  output logic [thgr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic [thgr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [thgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import thgr_pkg::*;
  `include "timed_hold_gesture_recognizer_unit_defines.svh"

  logic [WINDOW_W-1:0]   window_ms;
  logic [HOLD_MIN_W-1:0] hold_min_ms;
  logic [HOLDS_W-1:0]    required_holds;

  logic                  holding;
  logic [HOLDS_W-1:0]    good_holds;
  logic [TIME_BITS-1:0]  window_open_time;
  logic [TIME_BITS-1:0]  press_time;
  logic                  armed_latch;

  logic                  holding_next;
  logic [HOLDS_W-1:0]    good_holds_next;
  logic [TIME_BITS-1:0]  window_open_time_next;
  logic [TIME_BITS-1:0]  press_time_next;
  logic                  armed_latch_next;
  thgr_result_t          step_result;

  thgr_result_t          out_result;
  logic                  in_fire;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire = s_tvalid && s_tready;

  thgr_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .kind                  (s_tuser),
    .event_time            (s_tdata[TIME_BITS-1:0]),
    .window_ms             (window_ms),
    .hold_min_ms           (hold_min_ms),
    .required_holds        (required_holds),
    .holding               (holding),
    .good_holds            (good_holds),
    .window_open_time      (window_open_time),
    .press_time            (press_time),
    .armed_latch           (armed_latch),
    .holding_next          (holding_next),
    .good_holds_next       (good_holds_next),
    .window_open_time_next (window_open_time_next),
    .press_time_next       (press_time_next),
    .armed_latch_next      (armed_latch_next),
    .result                (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_MS_RESET;
      hold_min_ms <= HOLD_MIN_MS_RESET;
      required_holds <= REQUIRED_HOLDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_MS: window_ms <= cfg_wdata[WINDOW_W-1:0];
        CFG_HOLD_MIN_MS: hold_min_ms <= cfg_wdata[HOLD_MIN_W-1:0];
        CFG_REQUIRED_HOLDS: required_holds <= cfg_wdata[HOLDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
      good_holds <= '0;
      window_open_time <= '0;
      press_time <= '0;
      armed_latch <= 1'b0;
    end else if (in_fire) begin
      holding <= holding_next;
      good_holds <= good_holds_next;
      window_open_time <= window_open_time_next;
      press_time <= press_time_next;
      armed_latch <= armed_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-3){1'b0}}, out_result.armed_flag, out_result.status};

  `THGR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_tvalid && !armed_latch,
    "reset did not clear the result register and the armed latch")
  `THGR_ASSERT(a_result_tracks_latch, clk, rst, in_fire |=> out_result.armed_flag == armed_latch,
    "stored armed flag differs from the armed latch")
  `THGR_ASSERT(a_armed_status_sets_flag, clk, rst,
    m_tvalid && (out_result.status == ST_ARMED || out_result.status == ST_REJECTED)
    |-> out_result.armed_flag,
    "armed or rejected status without the armed flag")
  `THGR_ASSERT(a_latch_holds, clk, rst,
    armed_latch && !(in_fire && s_tuser == KIND_CLEAR) |=> armed_latch,
    "armed latch dropped without a clear event")
  `THGR_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready,
    "input stalled while the result register is empty")

endmodule
